// File: sv/ggcm_pkg.sv
// ----------------------------------------------------------------------------
// ggcm_pkg - shared types and constants for the GOST gamma mode core
// Cipher S-boxes, counter steps, rotation and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ggcm_pkg;

    localparam int unsigned BlockW = 64;
    localparam int unsigned HalfW  = 32;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned Rounds = 32;

    localparam logic [HalfW-1:0] HIGH_STEP = 32'd3452775555;
    localparam logic [HalfW-1:0] LOW_STEP  = 32'd2223466090;
    localparam int unsigned ROT_LEFT  = 11;
    localparam int unsigned ROT_RIGHT = 21;

    typedef enum logic [CfgIdxW-1:0] {
        REG_KEY_01 = 3'd0,
        REG_KEY_23 = 3'd1,
        REG_KEY_45 = 3'd2,
        REG_KEY_67 = 3'd3,
        REG_SYNC   = 3'd4
    } t_reg_idx;

    typedef logic [3:0] t_nib;

    // param-Z boxes, box 0 on the lowest nibble
    localparam t_nib SBOX [0:7][0:15] = '{
        '{4'hC,4'h4,4'h6,4'h2,4'hA,4'h5,4'hB,4'h9,4'hE,4'h8,4'hD,4'h7,4'h0,4'h3,4'hF,4'h1},
        '{4'h6,4'h8,4'h2,4'h3,4'h9,4'hA,4'h5,4'hC,4'h1,4'hE,4'h4,4'h7,4'hB,4'hD,4'h0,4'hF},
        '{4'hB,4'h3,4'h5,4'h8,4'h2,4'hF,4'hA,4'hD,4'hE,4'h1,4'h7,4'h4,4'hC,4'h9,4'h6,4'h0},
        '{4'hC,4'h8,4'h2,4'h1,4'hD,4'h4,4'hF,4'h6,4'h7,4'h0,4'hA,4'h5,4'h3,4'hE,4'h9,4'hB},
        '{4'h7,4'hF,4'h5,4'hA,4'h8,4'h1,4'h6,4'hD,4'h0,4'h9,4'h3,4'hE,4'hB,4'h4,4'h2,4'hC},
        '{4'h5,4'hD,4'hF,4'h6,4'h9,4'h2,4'hC,4'hA,4'hB,4'h7,4'h8,4'h1,4'h4,4'h3,4'hE,4'h0},
        '{4'h8,4'hE,4'h2,4'h5,4'h6,4'h9,4'h1,4'hC,4'hF,4'h4,4'hB,4'h0,4'hD,4'hA,4'h3,4'h7},
        '{4'h1,4'h7,4'hE,4'hD,4'h0,4'h5,4'h8,4'h3,4'h4,4'hF,4'hA,4'h6,4'h9,4'hC,4'hB,4'h2}
    };

endpackage

`default_nettype wire

// File: sv/ggcm_in_if.sv
// ----------------------------------------------------------------------------
// ggcm_in_if - input block channel
// Valid/ready channel carrying one data block and its message start flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ggcm_in_if;
    logic                            valid;
    logic                            ready;
    logic [ggcm_pkg::BlockW-1:0]     data_block;
    logic                            start_message;

    modport source (output valid, output data_block, output start_message, input ready);
    modport sink   (input valid, input data_block, input start_message, output ready);
endinterface

`default_nettype wire

// File: sv/ggcm_out_if.sv
// ----------------------------------------------------------------------------
// ggcm_out_if - result block channel
// Valid/ready channel carrying one combined cipher block.
// ----------------------------------------------------------------------------
`default_nettype none

interface ggcm_out_if;
    logic                            valid;
    logic                            ready;
    logic [ggcm_pkg::BlockW-1:0]     cipher_block;

    modport source (output valid, output cipher_block, input ready);
    modport sink   (input valid, input cipher_block, output ready);
endinterface

`default_nettype wire

// File: sv/ggcm_round.sv
// ----------------------------------------------------------------------------
// ggcm_round - one Feistel round of the block cipher
// Key add, eight S-boxes, rotate left by 11, XOR into the left half, swap.
// ----------------------------------------------------------------------------
`default_nettype none

module ggcm_round (
    input  wire logic [ggcm_pkg::HalfW-1:0] i_left,
    input  wire logic [ggcm_pkg::HalfW-1:0] i_right,
    input  wire logic [ggcm_pkg::HalfW-1:0] i_key,
    output logic      [ggcm_pkg::HalfW-1:0] o_left,
    output logic      [ggcm_pkg::HalfW-1:0] o_right
);

    logic [ggcm_pkg::HalfW-1:0] sum;
    logic [ggcm_pkg::HalfW-1:0] sub;
    logic [ggcm_pkg::HalfW-1:0] rot;

    assign sum = i_right + i_key;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            sub[4*i +: 4] = ggcm_pkg::SBOX[i][sum[4*i +: 4]];
        end
    end

    assign rot = (sub << ggcm_pkg::ROT_LEFT) | (sub >> ggcm_pkg::ROT_RIGHT);

    assign o_left  = i_right;
    assign o_right = rot ^ i_left;

endmodule

`default_nettype wire

// File: sv/gost_gamma_counter_mode_core.sv
// ----------------------------------------------------------------------------
// gost_gamma_counter_mode_core - counter (gamma) mode over the GOST 28147-89 cipher
// Steps two counters per block, enciphers them and XORs the gamma into data.
// ----------------------------------------------------------------------------
// One round unit is reused for every cipher round. A block is taken while the
// core is idle; a plain block then runs the cipher rounds and a finish step
// hands the word to the output register; no new block is taken before that.
// A block with start_message set first enciphers the sync value through the
// same rounds to seed the counters. The output register lets the next block
// be taken while a result waits; the core only stalls at the end of the rounds
// if that result is still there. Configuration writes take effect at once;
// index 5 and up is ignored.
`default_nettype none

module gost_gamma_counter_mode_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ggcm_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  wire logic [ggcm_pkg::BlockW-1:0]       i_cfg_data,
    ggcm_in_if.sink                                i_blk,
    ggcm_out_if.source                             o_res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_GAMMA,
        ST_FINISH
    } t_state;

    typedef logic [ggcm_pkg::HalfW-1:0] t_half;

    t_state                        r_state;
    logic [4:0]                    r_rnd;
    logic [ggcm_pkg::BlockW-1:0]   r_key [0:3];
    logic [ggcm_pkg::BlockW-1:0]   r_sync;
    t_half                         r_cnt_hi;
    t_half                         r_cnt_lo;
    t_half                         r_left;
    t_half                         r_right;
    logic [ggcm_pkg::BlockW-1:0]   r_data;
    logic [ggcm_pkg::BlockW-1:0]   r_out;
    logic                          r_out_valid;

    logic [2:0]  key_sel;
    logic [ggcm_pkg::BlockW-1:0] key_word;
    t_half       round_key;
    t_half       n_left;
    t_half       n_right;
    t_half       n_cnt_hi;
    t_half       n_cnt_lo;
    t_half       base_hi;
    t_half       base_lo;
    logic [ggcm_pkg::HalfW:0] lo_sum;
    logic        last_rnd;
    logic        out_free;

    // K0..K7 for rounds 0..23, then K7..K0
    assign key_sel   = (r_rnd < 5'd24) ? r_rnd[2:0] : ~r_rnd[2:0];
    assign key_word  = r_key[key_sel[2:1]];
    assign round_key = key_sel[0] ? key_word[63:32] : key_word[31:0];

    ggcm_round u_round (
        .i_left  (r_left),
        .i_right (r_right),
        .i_key   (round_key),
        .o_left  (n_left),
        .o_right (n_right)
    );

    // step from the seed after the last seed round, else from held counters
    assign base_hi = (r_state == ST_SEED) ? n_left  : r_cnt_hi;
    assign base_lo = (r_state == ST_SEED) ? n_right : r_cnt_lo;

    // low counter is modulo 2^32-1: fold the carry back in
    assign lo_sum   = {1'b0, base_lo} + {1'b0, ggcm_pkg::LOW_STEP};
    assign n_cnt_lo = lo_sum[ggcm_pkg::HalfW-1:0] + t_half'(lo_sum[ggcm_pkg::HalfW]);
    assign n_cnt_hi = base_hi + ggcm_pkg::HIGH_STEP;

    assign last_rnd = (r_rnd == 5'(ggcm_pkg::Rounds - 1));
    assign out_free = !r_out_valid || o_res.ready;

    assign i_blk.ready      = (r_state == ST_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.cipher_block = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rnd       <= '0;
            r_key       <= '{default: '0};
            r_sync      <= '0;
            r_cnt_hi    <= '0;
            r_cnt_lo    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ggcm_pkg::REG_KEY_01: r_key[0] <= i_cfg_data;
                    ggcm_pkg::REG_KEY_23: r_key[1] <= i_cfg_data;
                    ggcm_pkg::REG_KEY_45: r_key[2] <= i_cfg_data;
                    ggcm_pkg::REG_KEY_67: r_key[3] <= i_cfg_data;
                    ggcm_pkg::REG_SYNC:   r_sync   <= i_cfg_data;
                    default: ;
                endcase
            end

            // in the finish state the load below decides the flag
            if (r_out_valid && o_res.ready && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_blk.valid) begin
                        r_data <= i_blk.data_block;
                        r_rnd  <= '0;
                        if (i_blk.start_message) begin
                            r_left  <= r_sync[63:32];
                            r_right <= r_sync[31:0];
                            r_state <= ST_SEED;
                        end else begin
                            r_cnt_hi <= n_cnt_hi;
                            r_cnt_lo <= n_cnt_lo;
                            r_left   <= n_cnt_hi;
                            r_right  <= n_cnt_lo;
                            r_state  <= ST_GAMMA;
                        end
                    end
                end
                ST_SEED: begin
                    r_rnd <= r_rnd + 5'd1;
                    if (last_rnd) begin
                        r_cnt_hi <= n_cnt_hi;
                        r_cnt_lo <= n_cnt_lo;
                        r_left   <= n_cnt_hi;
                        r_right  <= n_cnt_lo;
                        r_state  <= ST_GAMMA;
                    end else begin
                        r_left  <= n_left;
                        r_right <= n_right;
                    end
                end
                ST_GAMMA: begin
                    r_rnd   <= r_rnd + 5'd1;
                    r_left  <= n_left;
                    r_right <= n_right;
                    if (last_rnd) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // hold until the previous word has gone
                    if (out_free) begin
                        r_out       <= r_data ^ {r_left, r_right};
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/ggcm_checker.sv
// ----------------------------------------------------------------------------
// ggcm_checker - port level checks for the gamma mode core
// Watches handshakes and result timing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ggcm_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [ggcm_pkg::BlockW-1:0]   i_out_data
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // busy for the rounds once a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input ready right after an accepted word");

    // no fresh result can rise in the cycle after an accept
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(i_out_valid))
        else $error("result appeared too soon after input");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("core not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result dropped or changed");

endmodule

bind gost_gamma_counter_mode_core ggcm_checker u_ggcm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_blk.valid),
    .i_in_ready  (i_blk.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.cipher_block)
);

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the GOST gamma mode core
// Feeds data blocks split into messages of random length, under random key and
// sync settings. It keeps its own copy of the counters and the cipher, and
// compares every returned cipher block with the block it predicts. Both
// channels idle at random, and the output side also holds off for a long time.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int LONG_HOLD     = 500;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 100;
    localparam int PHASES        = 12;
    localparam int PHASE_BLOCKS  = 116;

    localparam logic [ggcm_pkg::HalfW-1:0] HI_INC = 32'd3452775555;
    localparam logic [ggcm_pkg::HalfW-1:0] LO_INC = 32'd2223466090;
    localparam logic [ggcm_pkg::BlockW-1:0] ONES  = '1;

    typedef logic [ggcm_pkg::CfgIdxW-1:0] t_idx;

    // indexes past the sync register; writes there must be ignored
    localparam t_idx IDX_SPARE_FIRST = 3'd5;
    localparam t_idx IDX_SPARE_LAST  = '1;

    localparam logic [3:0] ZBOX [8][16] = '{
        '{4'hC,4'h4,4'h6,4'h2,4'hA,4'h5,4'hB,4'h9,4'hE,4'h8,4'hD,4'h7,4'h0,4'h3,4'hF,4'h1},
        '{4'h6,4'h8,4'h2,4'h3,4'h9,4'hA,4'h5,4'hC,4'h1,4'hE,4'h4,4'h7,4'hB,4'hD,4'h0,4'hF},
        '{4'hB,4'h3,4'h5,4'h8,4'h2,4'hF,4'hA,4'hD,4'hE,4'h1,4'h7,4'h4,4'hC,4'h9,4'h6,4'h0},
        '{4'hC,4'h8,4'h2,4'h1,4'hD,4'h4,4'hF,4'h6,4'h7,4'h0,4'hA,4'h5,4'h3,4'hE,4'h9,4'hB},
        '{4'h7,4'hF,4'h5,4'hA,4'h8,4'h1,4'h6,4'hD,4'h0,4'h9,4'h3,4'hE,4'hB,4'h4,4'h2,4'hC},
        '{4'h5,4'hD,4'hF,4'h6,4'h9,4'h2,4'hC,4'hA,4'hB,4'h7,4'h8,4'h1,4'h4,4'h3,4'hE,4'h0},
        '{4'h8,4'hE,4'h2,4'h5,4'h6,4'h9,4'h1,4'hC,4'hF,4'h4,4'hB,4'h0,4'hD,4'hA,4'h3,4'h7},
        '{4'h1,4'h7,4'hE,4'hD,4'h0,4'h5,4'h8,4'h3,4'h4,4'hF,4'hA,4'h6,4'h9,4'hC,4'hB,4'h2}
    };

    typedef struct {
        logic [ggcm_pkg::BlockW-1:0] data;
        logic                        start;
    } t_blk_item;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    t_idx                          i_cfg_idx;
    logic [ggcm_pkg::BlockW-1:0]   i_cfg_data;

    ggcm_in_if  blk_ch ();
    ggcm_out_if res_ch ();

    gost_gamma_counter_mode_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_blk      (blk_ch),
        .o_res      (res_ch)
    );

    // mirror of the core's registers and counters
    logic [ggcm_pkg::BlockW-1:0] cfg_regs [0:4];
    logic [ggcm_pkg::HalfW-1:0]  ctr_hi;
    logic [ggcm_pkg::HalfW-1:0]  ctr_lo;

    t_blk_item                   block_q [$];
    logic [ggcm_pkg::BlockW-1:0] cipher_q [$];

    int err_count;
    int src_gap_max;
    int rx_gap_max;
    int src_wait;
    int rx_wait;
    int hold_left;
    int hold_requests;
    int hold_served;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * 20);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [ggcm_pkg::HalfW-1:0] round_key(int k);
        logic [ggcm_pkg::BlockW-1:0] w;
        w = cfg_regs[k / 2];
        return (k % 2 == 1) ? w[63:32] : w[31:0];
    endfunction

    function automatic logic [ggcm_pkg::HalfW-1:0] feistel(logic [ggcm_pkg::HalfW-1:0] x,
                                                           logic [ggcm_pkg::HalfW-1:0] k);
        logic [ggcm_pkg::HalfW-1:0] s;
        logic [ggcm_pkg::HalfW-1:0] sub;
        s = x + k;
        for (int i = 0; i < 8; i++)
            sub[4*i +: 4] = ZBOX[i][s[4*i +: 4]];
        return {sub[20:0], sub[31:21]};
    endfunction

    function automatic logic [ggcm_pkg::BlockW-1:0] encipher64(
        logic [ggcm_pkg::BlockW-1:0] blk);
        logic [ggcm_pkg::HalfW-1:0] l;
        logic [ggcm_pkg::HalfW-1:0] r;
        logic [ggcm_pkg::HalfW-1:0] f;
        int k;
        l = blk[63:32];
        r = blk[31:0];
        for (int n = 0; n < 32; n++) begin
            // K0..K7 three times, then K7..K0
            k = (n < 24) ? (n % 8) : (31 - n);
            f = feistel(r, round_key(k)) ^ l;
            l = r;
            r = f;
        end
        return {l, r};
    endfunction

    task automatic predict_cipher(logic [ggcm_pkg::BlockW-1:0] data, logic start);
        logic [ggcm_pkg::BlockW-1:0] seed;
        logic [ggcm_pkg::HalfW:0]    lsum;
        if (start) begin
            seed   = encipher64(cfg_regs[ggcm_pkg::REG_SYNC]);
            ctr_hi = seed[63:32];
            ctr_lo = seed[31:0];
        end
        // low counter runs modulo 2^32-1: fold the carry back in
        lsum   = {1'b0, ctr_lo} + {1'b0, LO_INC};
        ctr_lo = lsum[ggcm_pkg::HalfW] ? lsum[31:0] + 32'd1 : lsum[31:0];
        ctr_hi = ctr_hi + HI_INC;
        cipher_q.push_back(data ^ encipher64({ctr_hi, ctr_lo}));
    endtask

    task automatic flag_error(string msg);
        err_count++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic check_cipher(logic [ggcm_pkg::BlockW-1:0] got);
        logic [ggcm_pkg::BlockW-1:0] want;
        if (cipher_q.size() == 0) begin
            flag_error($sformatf("cipher block %h with none expected", got));
        end else begin
            want = cipher_q.pop_front();
            if (got !== want)
                flag_error($sformatf("cipher block %h, expected %h", got, want));
        end
    endtask

    // driver: offer queued blocks, with a random gap after each accepted word
    always @(posedge i_clk) begin
        t_blk_item nxt;
        int        gap;
        logic      fire;
        if (!i_rst_n) begin
            blk_ch.valid <= 1'b0;
            src_wait     <= 0;
        end else begin
            fire = blk_ch.valid && blk_ch.ready;
            gap  = src_wait;
            if (fire) begin
                predict_cipher(blk_ch.data_block, blk_ch.start_message);
                gap = $urandom_range(0, src_gap_max);
            end
            if (blk_ch.valid && !fire) begin
                // hold the word until it is taken
            end else if (gap > 0) begin
                blk_ch.valid <= 1'b0;
                src_wait     <= gap - 1;
            end else if (block_q.size() > 0) begin
                nxt = block_q.pop_front();
                blk_ch.valid         <= 1'b1;
                blk_ch.data_block    <= nxt.data;
                blk_ch.start_message <= nxt.start;
                src_wait             <= 0;
            end else begin
                blk_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: take results, stall at random, hold off for long on request
    always @(posedge i_clk) begin
        logic take;
        int   d;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            rx_wait      <= 0;
            hold_left    <= 0;
            hold_served  <= 0;
        end else begin
            take = res_ch.valid && res_ch.ready;
            if (take)
                check_cipher(res_ch.cipher_block);
            if (hold_served != hold_requests) begin
                hold_served  <= hold_requests;
                hold_left    <= LONG_HOLD;
                res_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                res_ch.ready <= (hold_left == 1);
            end else if (take) begin
                d = $urandom_range(0, rx_gap_max);
                rx_wait      <= d;
                res_ch.ready <= (d == 0);
            end else if (rx_wait > 0) begin
                rx_wait      <= rx_wait - 1;
                res_ch.ready <= (rx_wait == 1);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [ggcm_pkg::BlockW-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ggcm_pkg::BlockW-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return ONES;
            default: return rand64();
        endcase
    endfunction

    task automatic cfg_write(t_idx idx, logic [ggcm_pkg::BlockW-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx <= ggcm_pkg::REG_SYNC)
            cfg_regs[idx] = val;
    endtask

    task automatic cfg_done();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic queue_block(logic [ggcm_pkg::BlockW-1:0] data, logic start);
        t_blk_item it;
        it.data  = data;
        it.start = start;
        block_q.push_back(it);
    endtask

    // pause the sender until every predicted word has come back
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (block_q.size() != 0 || blk_ch.valid || cipher_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [ggcm_pkg::BlockW-1:0] v;
        int n;
        int len;
        logic st;

        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = ggcm_pkg::REG_KEY_01;
        i_cfg_data           = '0;
        err_count            = 0;
        hold_requests        = 0;
        src_gap_max          = 10;
        rx_gap_max           = 10;
        ctr_hi               = '0;
        ctr_lo               = '0;
        for (int i = 0; i <= ggcm_pkg::REG_SYNC; i++)
            cfg_regs[i] = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero counters stepped before any message start, zero keys
        queue_block('0, 1'b0);
        queue_block(ONES, 1'b0);
        queue_block(rand64(), 1'b1);
        wait_drained();

        // all-ones keys and sync; spare indexes must not disturb them
        cfg_write(ggcm_pkg::REG_KEY_01, ONES);
        cfg_write(ggcm_pkg::REG_KEY_23, ONES);
        cfg_write(ggcm_pkg::REG_KEY_45, ONES);
        cfg_write(ggcm_pkg::REG_KEY_67, ONES);
        cfg_write(ggcm_pkg::REG_SYNC, ONES);
        for (int i = IDX_SPARE_FIRST; i <= IDX_SPARE_LAST; i++)
            cfg_write(t_idx'(i), rand64());
        cfg_done();
        queue_block(ONES, 1'b1);
        queue_block('0, 1'b0);
        queue_block({32{2'b01}}, 1'b0);
        queue_block({32{2'b10}}, 1'b0);
        wait_drained();

        // new keys in the middle of a message act at once
        cfg_write(ggcm_pkg::REG_KEY_01, rand64());
        cfg_write(ggcm_pkg::REG_KEY_23, rand64());
        cfg_write(ggcm_pkg::REG_KEY_45, rand64());
        cfg_write(ggcm_pkg::REG_KEY_67, rand64());
        cfg_done();
        queue_block(rand64(), 1'b0);
        queue_block(rand64(), 1'b0);
        wait_drained();

        // a new sync mid-message is used only at the next start
        cfg_write(ggcm_pkg::REG_SYNC, rand64());
        cfg_done();
        queue_block(rand64(), 1'b0);
        queue_block(rand64(), 1'b1);
        queue_block(rand64(), 1'b0);
        wait_drained();

        // zero sync, back-to-back message starts
        cfg_write(ggcm_pkg::REG_KEY_01, '0);
        cfg_write(ggcm_pkg::REG_KEY_67, rand64());
        cfg_write(ggcm_pkg::REG_SYNC, '0);
        cfg_done();
        queue_block(rand64(), 1'b1);
        queue_block(rand64(), 1'b1);
        queue_block(rand64(), 1'b1);
        queue_block('0, 1'b0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            for (int r = ggcm_pkg::REG_KEY_01; r <= ggcm_pkg::REG_SYNC; r++) begin
                if ($urandom_range(0, 1) == 1) begin
                    case ($urandom_range(0, 5))
                        0:       v = '0;
                        1:       v = ONES;
                        default: v = rand64();
                    endcase
                    cfg_write(t_idx'(r), v);
                end
            end
            if ($urandom_range(0, 2) == 0)
                cfg_write(t_idx'($urandom_range(IDX_SPARE_FIRST, IDX_SPARE_LAST)), rand64());
            cfg_done();

            src_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            rx_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 10;
            // fill the core while the output side holds off
            if (p == 1)
                hold_requests++;

            n = 0;
            while (n < PHASE_BLOCKS) begin
                // the first message may carry on from the last phase
                st  = (n == 0) ? ($urandom_range(0, 3) != 0) : 1'b1;
                len = $urandom_range(1, 9);
                for (int j = 0; j < len && n < PHASE_BLOCKS; j++) begin
                    queue_block(pick_word(), (j == 0) ? st : 1'b0);
                    n++;
                end
            end
            wait_drained();
        end

        repeat (END_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: gost_gamma_counter_mode_core.f
sv/ggcm_pkg.sv
sv/ggcm_in_if.sv
sv/ggcm_out_if.sv
sv/ggcm_round.sv
sv/gost_gamma_counter_mode_core.sv
sv/ggcm_checker.sv
bench/tb.sv
